[sv/tmp_pkg.sv]
// ----------------------------------------------------------------------------
// tmp_pkg
// shared constants and types for the trapezoidal motion profile evaluator
// ----------------------------------------------------------------------------
package tmp_pkg;

    localparam int FRACTION_BITS_DEF = 16;

    // width of the shared divider dividend and quotient
    localparam int DIV_W = 64;

    // configuration register indexes
    localparam logic [2:0] CFG_ACCEL_RATE     = 3'd0;
    localparam logic [2:0] CFG_DECEL_RATE     = 3'd1;
    localparam logic [2:0] CFG_MAX_SPEED      = 3'd2;
    localparam logic [2:0] CFG_START_POSITION = 3'd3;
    localparam logic [2:0] CFG_END_POSITION   = 3'd4;

    // phase codes
    localparam logic [1:0] PH_ACCEL  = 2'd0;
    localparam logic [1:0] PH_CRUISE = 2'd1;
    localparam logic [1:0] PH_DECEL  = 2'd2;
    localparam logic [1:0] PH_DONE   = 2'd3;

    typedef struct packed {
        logic busy;     // move parameters being derived
        logic mv_zero;  // no motion possible
        logic neg;      // move runs towards lower positions
    } t_setup_status;

endpackage

[sv/tmp_setup.sv]
// ----------------------------------------------------------------------------
// tmp_setup
// derives peak speed and phase durations from the move configuration
// ----------------------------------------------------------------------------
module tmp_setup #(
    parameter int FRACTION_BITS = tmp_pkg::FRACTION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [31:0]                   i_accel_rate,
    input  logic [31:0]                   i_decel_rate,
    input  logic [31:0]                   i_max_speed,
    input  logic signed [31:0]            i_start_position,
    input  logic signed [31:0]            i_end_position,
    output tmp_pkg::t_setup_status        o_status,
    output logic [32+FRACTION_BITS-1:0]   o_ta,
    output logic [32+FRACTION_BITS-1:0]   o_td,
    output logic [32+FRACTION_BITS-1:0]   o_tc,
    output logic [31:0]                   o_mv,
    output logic [63:0]                   o_da
);
    import tmp_pkg::*;

    localparam int TW    = 32 + FRACTION_BITS;
    localparam int PAD_W = DIV_W - TW;

    typedef enum logic [3:0] {
        ST_MUL, ST_DIV_H, ST_PROD, ST_SQRT, ST_MV,
        ST_DIV_TA, ST_DIV_TD, ST_DIV_Q, ST_TC, ST_IDLE
    } t_state;

    t_state            r_state;
    logic [DIV_W-1:0]  r_dq;
    logic [33:0]       r_rem;
    logic [32:0]       r_dsor;
    logic [5:0]        r_cnt;
    logic              r_hzero;
    logic [31:0]       r_h;
    logic [31:0]       r_dist;
    logic              r_neg;
    logic [63:0]       r_sx;
    logic [63:0]       r_sr;
    logic [63:0]       r_sbit;
    logic              r_nocap;
    logic [31:0]       r_mv;
    logic              r_mv_zero;
    logic [TW-1:0]     r_ta;
    logic [TW-1:0]     r_td;
    logic [TW-1:0]     r_q;
    logic [TW-1:0]     r_tc;
    logic [63:0]       r_da;

    // divider step
    logic [33:0]       rem_sh;
    logic              q_bit;
    logic [33:0]       n_rem;
    logic [DIV_W-1:0]  n_dq;
    logic              div_last;

    // square root step
    logic [64:0]       sq_sum;
    logic              sq_ge;
    logic [63:0]       n_sx;
    logic [63:0]       n_sr;

    // misc datapath
    logic signed [32:0] pos_diff;
    logic [63:0]        ad_prod;
    logic [32:0]        ad_sum;
    logic [63:0]        dh_prod;
    logic [31:0]        mv_cap;
    logic [TW:0]        t_sum;
    logic [TW-1:0]      t_half;
    logic [63:0]        da_prod;
    logic [DIV_W-1:0]   mv_shift;
    logic [DIV_W-1:0]   dist_shift;

    always_comb begin
        rem_sh   = {r_rem[32:0], r_dq[DIV_W-1]};
        q_bit    = (rem_sh >= {1'b0, r_dsor});
        n_rem    = q_bit ? (rem_sh - {1'b0, r_dsor}) : rem_sh;
        n_dq     = {r_dq[DIV_W-2:0], q_bit};
        div_last = (r_cnt == 6'd63);

        sq_sum = {1'b0, r_sr} + {1'b0, r_sbit};
        sq_ge  = ({1'b0, r_sx} >= sq_sum);
        n_sx   = sq_ge ? (r_sx - sq_sum[63:0]) : r_sx;
        n_sr   = sq_ge ? ((r_sr >> 1) + r_sbit) : (r_sr >> 1);

        pos_diff = 33'(i_end_position) - 33'(i_start_position);
        ad_prod  = {32'd0, i_accel_rate} * {32'd0, i_decel_rate};
        ad_sum   = {1'b0, i_accel_rate} + {1'b0, i_decel_rate};
        dh_prod  = {32'd0, r_dist} * {32'd0, r_h};

        // candidate peak speed from the final root step
        if (r_nocap || (n_sr[31:0] >= i_max_speed)) begin
            mv_cap = i_max_speed;
        end else begin
            mv_cap = n_sr[31:0];
        end

        t_sum   = {1'b0, r_ta} + {1'b0, r_td};
        t_half  = t_sum[TW:1];
        da_prod = {32'd0, r_mv} * {32'd0, r_ta[31:0]};

        mv_shift   = {{PAD_W{1'b0}}, r_mv, {FRACTION_BITS{1'b0}}};
        dist_shift = {{PAD_W{1'b0}}, r_dist, {FRACTION_BITS{1'b0}}};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_MUL;
            r_mv_zero <= 1'b0;
        end else if (i_start) begin
            r_state <= ST_MUL;
        end else begin
            case (r_state)
                ST_MUL: begin
                    r_dist  <= pos_diff[32] ? 32'(-pos_diff) : pos_diff[31:0];
                    r_neg   <= pos_diff[32];
                    r_hzero <= (ad_sum == 33'd0);
                    r_dq    <= ad_prod;
                    r_dsor  <= ad_sum;
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= ST_DIV_H;
                end
                ST_DIV_H: begin
                    r_dq  <= n_dq;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt + 6'd1;
                    if (div_last) begin
                        r_h     <= r_hzero ? 32'd0 : n_dq[31:0];
                        r_state <= ST_PROD;
                    end
                end
                ST_PROD: begin
                    r_sx    <= {dh_prod[62:0], 1'b0};
                    r_nocap <= dh_prod[63];
                    r_sr    <= '0;
                    r_sbit  <= 64'd1 << 62;
                    r_state <= ST_SQRT;
                end
                ST_SQRT: begin
                    r_sx   <= n_sx;
                    r_sr   <= n_sr;
                    r_sbit <= r_sbit >> 2;
                    if (r_sbit == 64'd1) begin
                        r_mv    <= mv_cap;
                        r_state <= ST_MV;
                    end
                end
                ST_MV: begin
                    r_mv_zero <= (r_mv == 32'd0);
                    r_dq      <= mv_shift;
                    r_dsor    <= {1'b0, i_accel_rate};
                    r_rem     <= '0;
                    r_cnt     <= '0;
                    r_state   <= (r_mv == 32'd0) ? ST_IDLE : ST_DIV_TA;
                end
                ST_DIV_TA: begin
                    r_dq  <= n_dq;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt + 6'd1;
                    if (div_last) begin
                        r_ta    <= n_dq[TW-1:0];
                        r_dq    <= mv_shift;
                        r_dsor  <= {1'b0, i_decel_rate};
                        r_rem   <= '0;
                        r_state <= ST_DIV_TD;
                    end
                end
                ST_DIV_TD: begin
                    r_dq  <= n_dq;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt + 6'd1;
                    if (div_last) begin
                        r_td    <= n_dq[TW-1:0];
                        r_dq    <= dist_shift;
                        r_dsor  <= {1'b0, r_mv};
                        r_rem   <= '0;
                        r_state <= ST_DIV_Q;
                    end
                end
                ST_DIV_Q: begin
                    r_dq  <= n_dq;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt + 6'd1;
                    if (div_last) begin
                        r_q     <= n_dq[TW-1:0];
                        r_state <= ST_TC;
                    end
                end
                ST_TC: begin
                    r_tc    <= (r_q > t_half) ? (r_q - t_half) : '0;
                    r_da    <= da_prod >> (FRACTION_BITS + 1);
                    r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_MUL;
                end
            endcase
        end
    end

    assign o_status.busy    = (r_state != ST_IDLE);
    assign o_status.mv_zero = r_mv_zero;
    assign o_status.neg     = r_neg;
    assign o_ta = r_ta;
    assign o_td = r_td;
    assign o_tc = r_tc;
    assign o_mv = r_mv;
    assign o_da = r_da;

endmodule

[sv/trapezoidal_motion_profile.sv]
// ----------------------------------------------------------------------------
// trapezoidal_motion_profile
// evaluates a configured trapezoidal move at a requested elapsed time
// ----------------------------------------------------------------------------
// usage
//   software writes accel, decel, peak speed, start and end positions on the
//   plain write port; every write restarts the derivation of the capped peak
//   speed and the phase durations (four 64-step divisions through one
//   shared radix-2 divider plus a 32-step square root; when no motion is
//   possible the last three divisions are skipped). after reset the same
//   derivation runs on the reset values. while it runs o_stall stays high
//   and no request is taken.
//   input channel i_valid / o_stall carries one elapsed time per request;
//   output channel o_valid / i_stall returns phase, accel, speed, position.
//   the evaluator is a seven-stage pipeline: one request per clock while
//   o_stall is low. when the receiver stalls with a result waiting, the
//   whole pipeline holds and o_stall rises, so nothing is lost or repeated.
//   reset clears all valid bits.
// ----------------------------------------------------------------------------
module trapezoidal_motion_profile #(
    parameter int FRACTION_BITS = tmp_pkg::FRACTION_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration write port
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    // request channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [31:0]        i_elapsed_time,
    // result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_phase,
    output logic [31:0]        o_accel_out,
    output logic [31:0]        o_speed_out,
    output logic signed [31:0] o_position_out
);
    import tmp_pkg::*;

    localparam int TW = 32 + FRACTION_BITS;

    // configuration registers
    logic [31:0]        r_accel_rate;
    logic [31:0]        r_decel_rate;
    logic [31:0]        r_max_speed;
    logic signed [31:0] r_start_position;
    logic signed [31:0] r_end_position;

    // derived move parameters
    t_setup_status st;
    logic [TW-1:0] ta;
    logic [TW-1:0] td;
    logic [TW-1:0] tc;
    logic [31:0]   mv;
    logic [63:0]   da;

    // pipeline control
    logic en;
    logic accept;
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_ov;

    // stage 1: time against end of acceleration
    logic [31:0] r1_t;
    logic        r1_p0;
    logic [31:0] r1_w;
    // stage 2: cruise test and first products
    logic [31:0] r2_t;
    logic        r2_p0;
    logic        r2_in_c;
    logic [31:0] r2_u;
    logic [63:0] r2_at;
    logic [63:0] r2_mw;
    // stage 3: deceleration test
    logic [31:0] r3_t;
    logic        r3_p0;
    logic        r3_in_c;
    logic        r3_in_d;
    logic [31:0] r3_u;
    logic [31:0] r3_v0;
    logic [63:0] r3_du;
    logic [63:0] r3_base;
    // stage 4: phase decided, second products
    logic [1:0]  r4_phase;
    logic [31:0] r4_acc;
    logic [31:0] r4_spd;
    logic [63:0] r4_v0t;
    logic [63:0] r4_dvu;
    logic [63:0] r4_base;
    // stage 5: travelled distance
    logic [1:0]  r5_phase;
    logic [31:0] r5_acc;
    logic [31:0] r5_spd;
    logic [63:0] r5_mag;
    // stage 6: unsaturated position
    logic [1:0]  r6_phase;
    logic [31:0] r6_acc;
    logic [31:0] r6_spd;
    logic [63:0] r6_pos;
    // output register
    logic [1:0]         r_phase;
    logic [31:0]        r_acc;
    logic [31:0]        r_spd;
    logic signed [31:0] r_pos;

    // combinational stage logic
    logic        lt_a;
    logic        in_c;
    logic        in_d;
    logic [31:0] dv;
    logic [1:0]  n_phase;
    logic [31:0] n_acc;
    logic [31:0] n_spd;
    logic [63:0] n_mag;
    logic [63:0] s64;
    logic [63:0] n_pos;
    logic [31:0] n_sat;

    // ------------------------------------------------------------------
    // configuration registers, writes beyond the list are ignored
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_rate     <= 32'h0001_0000;
            r_decel_rate     <= 32'h0001_0000;
            r_max_speed      <= 32'h0001_0000;
            r_start_position <= '0;
            r_end_position   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ACCEL_RATE:     r_accel_rate     <= i_cfg_data;
                CFG_DECEL_RATE:     r_decel_rate     <= i_cfg_data;
                CFG_MAX_SPEED:      r_max_speed      <= i_cfg_data;
                CFG_START_POSITION: r_start_position <= i_cfg_data;
                CFG_END_POSITION:   r_end_position   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // peak speed cap, phase durations and acceleration distance
    tmp_setup #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_setup (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_cfg_we),
        .i_accel_rate     (r_accel_rate),
        .i_decel_rate     (r_decel_rate),
        .i_max_speed      (r_max_speed),
        .i_start_position (r_start_position),
        .i_end_position   (r_end_position),
        .o_status         (st),
        .o_ta             (ta),
        .o_td             (td),
        .o_tc             (tc),
        .o_mv             (mv),
        .o_da             (da)
    );

    // the whole pipeline moves unless a finished result is held up
    assign en      = !(r_ov && i_stall);
    assign o_stall = st.busy || !en;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v1 <= accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_ov <= r_v6;
        end
    end

    // ------------------------------------------------------------------
    // stage logic
    // ------------------------------------------------------------------
    always_comb begin
        // accelerating while t is below the acceleration time
        lt_a = ({{(TW-32){1'b0}}, i_elapsed_time} < ta);
        // w = t - ta is exact whenever the request is past acceleration
        in_c = ({{(TW-32){1'b0}}, r1_w} < tc);
        in_d = ({{(TW-32){1'b0}}, r2_u} < td);

        // speed lost since deceleration began, below the peak in that phase
        dv = r3_du[FRACTION_BITS +: 32];

        if (st.mv_zero) begin
            n_phase = PH_DONE;
        end else if (r3_p0) begin
            n_phase = PH_ACCEL;
        end else if (r3_in_c) begin
            n_phase = PH_CRUISE;
        end else if (r3_in_d) begin
            n_phase = PH_DECEL;
        end else begin
            n_phase = PH_DONE;
        end

        case (n_phase)
            PH_ACCEL: begin
                n_acc = r_accel_rate;
                n_spd = r3_v0;
            end
            PH_CRUISE: begin
                n_acc = 32'd0;
                n_spd = mv;
            end
            PH_DECEL: begin
                n_acc = r_decel_rate;
                n_spd = (dv >= mv) ? 32'd0 : (mv - dv);
            end
            default: begin
                n_acc = 32'd0;
                n_spd = 32'd0;
            end
        endcase

        case (r4_phase)
            PH_ACCEL:  n_mag = r4_v0t >> (FRACTION_BITS + 1);
            PH_CRUISE: n_mag = r4_base;
            PH_DECEL:  n_mag = r4_base - (r4_dvu >> (FRACTION_BITS + 1));
            default:   n_mag = 64'd0;
        endcase

        // signed offset from the start position, 64-bit wrap
        s64   = {{32{r_start_position[31]}}, r_start_position};
        n_pos = st.neg ? (s64 - r5_mag) : (s64 + r5_mag);

        // clamp to the signed 32-bit range
        if (!r6_pos[63] && (|r6_pos[62:31])) begin
            n_sat = 32'h7FFF_FFFF;
        end else if (r6_pos[63] && !(&r6_pos[62:31])) begin
            n_sat = 32'h8000_0000;
        end else begin
            n_sat = r6_pos[31:0];
        end
    end

    // ------------------------------------------------------------------
    // pipeline payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (en) begin
            // stage 1
            r1_t  <= i_elapsed_time;
            r1_p0 <= lt_a;
            r1_w  <= i_elapsed_time - ta[31:0];
            // stage 2
            r2_t    <= r1_t;
            r2_p0   <= r1_p0;
            r2_in_c <= in_c;
            r2_u    <= r1_w - tc[31:0];
            r2_at   <= {32'd0, r_accel_rate} * {32'd0, r1_t};
            r2_mw   <= {32'd0, mv} * {32'd0, r1_w};
            // stage 3
            r3_t    <= r2_t;
            r3_p0   <= r2_p0;
            r3_in_c <= r2_in_c;
            r3_in_d <= in_d;
            r3_u    <= r2_u;
            r3_v0   <= r2_at[FRACTION_BITS +: 32];
            r3_du   <= {32'd0, r_decel_rate} * {32'd0, r2_u};
            r3_base <= da + (r2_mw >> FRACTION_BITS);
            // stage 4
            r4_phase <= n_phase;
            r4_acc   <= n_acc;
            r4_spd   <= n_spd;
            r4_v0t   <= {32'd0, r3_v0} * {32'd0, r3_t};
            r4_dvu   <= {32'd0, dv} * {32'd0, r3_u};
            r4_base  <= r3_base;
            // stage 5
            r5_phase <= r4_phase;
            r5_acc   <= r4_acc;
            r5_spd   <= r4_spd;
            r5_mag   <= n_mag;
            // stage 6
            r6_phase <= r5_phase;
            r6_acc   <= r5_acc;
            r6_spd   <= r5_spd;
            r6_pos   <= n_pos;
            // output, a finished move sits at the end position
            r_phase <= r6_phase;
            r_acc   <= r6_acc;
            r_spd   <= r6_spd;
            r_pos   <= (r6_phase == PH_DONE) ? r_end_position : n_sat;
        end
    end

    assign o_valid        = r_ov;
    assign o_phase        = r_phase;
    assign o_accel_out    = r_acc;
    assign o_speed_out    = r_spd;
    assign o_position_out = r_pos;

endmodule
